### rtl/pce_pkg.sv
// ----------------------------------------------------------------------------
// pce_pkg
// Types, constants and small helper functions shared by the Playfair engine.
// ----------------------------------------------------------------------------
package pce_pkg;

	localparam int OPCODE_W   = 3;
	localparam int CHAR_W     = 8;
	localparam int LETTER_W   = 7;
	localparam int LET_IDX_W  = 5;
	localparam int GRID_CELLS = 25;
	localparam int ALPHA_SIZE = 26;

	localparam logic [LET_IDX_W-1:0] LET_I     = 5'd8;
	localparam logic [LET_IDX_W-1:0] LET_J     = 5'd9;
	localparam logic [LET_IDX_W-1:0] LET_X     = 5'd23;
	localparam logic [LET_IDX_W-1:0] LET_LAST  = 5'd25;
	localparam logic [LET_IDX_W-1:0] GRID_FULL = 5'd25;
	localparam logic [2:0]           SIDE_LAST = 3'd4;
	localparam logic [LETTER_W-1:0]  ASCII_A   = 7'd65;

	typedef enum logic [OPCODE_W-1:0] {
		OP_KEY_START = 3'd0,
		OP_KEY_BYTE  = 3'd1,
		OP_KEY_END   = 3'd2,
		OP_TEXT_BYTE = 3'd3,
		OP_TEXT_END  = 3'd4
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KEYFILL,
		ST_LK_A,
		ST_LK_B,
		ST_LK_G1,
		ST_LK_G2,
		ST_LK_G3,
		ST_EM_HELD,
		ST_EM_P1,
		ST_EM_P2,
		ST_EM_BARE
	} state_t;

	typedef struct packed {
		logic                 ok;
		logic [LET_IDX_W-1:0] idx;
	} let_t;

	function automatic let_t to_letter(input logic [CHAR_W-1:0] b);
		logic [CHAR_W-1:0] c;
		let_t              r;
		c = b;
		if (c >= 8'h61 && c <= 8'h7a) begin
			c = c - 8'd32;
		end
		r.ok  = (c >= 8'h41) && (c <= 8'h5a);
		r.idx = LET_IDX_W'(c - 8'h41);
		if (r.idx == LET_J) begin
			r.idx = LET_I;
		end
		return r;
	endfunction

	function automatic logic [LET_IDX_W-1:0] grid_reset(input logic [LET_IDX_W-1:0] s);
		return (s < LET_J) ? s : LET_IDX_W'(s + 5'd1);
	endfunction

	function automatic logic [LET_IDX_W-1:0] pos_reset(input logic [LET_IDX_W-1:0] l);
		logic [LET_IDX_W-1:0] r;
		priority if (l < LET_J) begin
			r = l;
		end else if (l == LET_J) begin
			r = LET_I;
		end else begin
			r = LET_IDX_W'(l - 5'd1);
		end
		return r;
	endfunction

	function automatic logic [2:0] cell_row(input logic [LET_IDX_W-1:0] p);
		logic [2:0] r;
		priority if (p >= 5'd20) begin
			r = 3'd4;
		end else if (p >= 5'd15) begin
			r = 3'd3;
		end else if (p >= 5'd10) begin
			r = 3'd2;
		end else if (p >= 5'd5) begin
			r = 3'd1;
		end else begin
			r = 3'd0;
		end
		return r;
	endfunction

	function automatic logic [LET_IDX_W-1:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
		return LET_IDX_W'({r, 2'b00}) + LET_IDX_W'(r) + LET_IDX_W'(c);
	endfunction

	function automatic logic [2:0] cell_col(input logic [LET_IDX_W-1:0] p);
		return 3'(p - cell_addr(cell_row(p), 3'd0));
	endfunction

	function automatic logic [2:0] side_shift(input logic [2:0] x, input logic back);
		logic [2:0] r;
		if (back) begin
			r = (x == 3'd0) ? SIDE_LAST : 3'(x - 3'd1);
		end else begin
			r = (x == SIDE_LAST) ? 3'd0 : 3'(x + 3'd1);
		end
		return r;
	endfunction

endpackage

### rtl/pce_cmd_if.sv
// ----------------------------------------------------------------------------
// pce_cmd_if
// Command channel: opcode and raw character byte with valid/ready.
// ----------------------------------------------------------------------------
interface pce_cmd_if
	import pce_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [CHAR_W-1:0]   char_code;

	modport source(output valid, output opcode, output char_code, input ready);
	modport sink(input valid, input opcode, input char_code, output ready);
endinterface

### rtl/pce_res_if.sv
// ----------------------------------------------------------------------------
// pce_res_if
// Result channel: output letter and flags with valid/ready.
// ----------------------------------------------------------------------------
interface pce_res_if
	import pce_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [LETTER_W-1:0] letter;
	logic                letter_valid;
	logic                end_of_text;

	modport source(output valid, output letter, output letter_valid, output end_of_text,
		input ready);
	modport sink(input valid, input letter, input letter_valid, input end_of_text,
		output ready);
endinterface

### rtl/pce_ram.sv
// ----------------------------------------------------------------------------
// pce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pce_ram #(
	parameter int  WIDTH = 5,
	parameter int  DEPTH = 25,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

### rtl/playfair_cipher_engine_core.sv
// ----------------------------------------------------------------------------
// playfair_cipher_engine_core
// Streaming Playfair cipher: key entry builds the 5x5 grid, text is paired
// and enciphered or deciphered one pair at a time.
//
// cmd carries opcode and char_code; an item transfers when valid and ready
// are high. res carries letter, letter_valid and end_of_text, up to three
// results per item, held in one output register.
// cfg_we/cfg_wdata write the direction bit (0 encrypt, 1 decrypt); the user
// must write it only while idle, which the block itself does not enforce.
// Key end places each unused letter but J, A to Z, in the next free grid slot.
// A completed pair is looked up in LK_A, LK_B, LK_G1, LK_G2 and LK_G3 (two
// position reads and two grid reads through the single read port of each
// memory), then emits; text end without an open pair emits straight away.
// Grid and letter positions live in two RAMs; per-entry valid flops make
// unwritten entries read as the default alphabet, so reset needs no sweep.
// Reset clears the key state, open pair and held letter; the grid returns
// to A..Z without J. A stalled res holds the current result and the engine
// waits; cmd ready returns high once the last result of an item is loaded.
// ----------------------------------------------------------------------------
module playfair_cipher_engine_core
	import pce_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	pce_cmd_if.sink   cmd,
	pce_res_if.source res,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);
	state_t state_q, state_d;

	logic                 dir_q;
	logic [ALPHA_SIZE-1:0] used_q;
	logic [LET_IDX_W-1:0] fill_q;
	logic [LET_IDX_W-1:0] cnt_q;
	logic [LET_IDX_W-1:0] pend_let_q;
	logic                 pend_vld_q;
	logic [LET_IDX_W-1:0] held_let_q;
	logic                 held_vld_q;

	logic [LET_IDX_W-1:0] a_q, b_q;
	logic [LET_IDX_W-1:0] h_let_q;
	logic                 h_en_q;
	logic                 end_q;
	logic                 pair_q;
	logic [LET_IDX_W-1:0] pa_q;
	logic [LET_IDX_W-1:0] addr2_q;
	logic [LET_IDX_W-1:0] p1_q, p2_q;

	logic [GRID_CELLS-1:0] grid_vld_q;
	logic [ALPHA_SIZE-1:0] pos_vld_q;
	logic                  grid_rv_q, pos_rv_q;
	logic [LET_IDX_W-1:0]  grid_ra_q, pos_ra_q;

	logic                 res_valid_q;
	logic [LETTER_W-1:0]  res_letter_q;
	logic                 res_lv_q;
	logic                 res_eot_q;

	logic                 acc;
	let_t                 in_let;
	logic                 out_free;
	logic                 load;
	logic [LETTER_W-1:0]  ld_letter;
	logic                 ld_lv;
	logic                 ld_eot;
	logic                 p2_en;
	logic                 h_en_new;
	logic                 place_req;
	logic [LET_IDX_W-1:0] place_let;
	logic                 place_do;

	logic [LET_IDX_W-1:0] grid_raddr, pos_raddr;
	logic [LET_IDX_W-1:0] grid_rdata, pos_rdata;
	logic [LET_IDX_W-1:0] grid_rd, pos_rd;

	logic [2:0]           ra, ca, rb, cb;
	logic [LET_IDX_W-1:0] a1, a2;

	pce_ram #(.WIDTH(LET_IDX_W), .DEPTH(GRID_CELLS)) u_grid (
		.clk   (clk),
		.we    (place_do),
		.waddr (fill_q),
		.wdata (place_let),
		.raddr (grid_raddr),
		.rdata (grid_rdata)
	);

	pce_ram #(.WIDTH(LET_IDX_W), .DEPTH(ALPHA_SIZE)) u_pos (
		.clk   (clk),
		.we    (place_do),
		.waddr (place_let),
		.wdata (fill_q),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	assign acc      = cmd.valid && cmd.ready;
	assign in_let   = to_letter(cmd.char_code);
	assign out_free = !res_valid_q || res.ready;
	assign grid_rd  = grid_rv_q ? grid_rdata : grid_reset(grid_ra_q);
	assign pos_rd   = pos_rv_q ? pos_rdata : pos_reset(pos_ra_q);
	assign p2_en    = end_q ? (!dir_q || p2_q != LET_X) : !dir_q;
	assign h_en_new = held_vld_q && (pend_vld_q || !dir_q || held_let_q != LET_X);
	assign place_do = place_req && !used_q[place_let] && (fill_q < GRID_FULL);

	always_comb begin
		ra = cell_row(pa_q);
		ca = cell_col(pa_q);
		rb = cell_row(pos_rd);
		cb = cell_col(pos_rd);
		priority if (ra == rb) begin
			a1 = cell_addr(ra, side_shift(ca, dir_q));
			a2 = cell_addr(rb, side_shift(cb, dir_q));
		end else if (ca == cb) begin
			a1 = cell_addr(side_shift(ra, dir_q), ca);
			a2 = cell_addr(side_shift(rb, dir_q), cb);
		end else begin
			a1 = cell_addr(ra, cb);
			a2 = cell_addr(rb, ca);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (cmd.opcode == OP_KEY_END) begin
						state_d = ST_KEYFILL;
					end else if (cmd.opcode == OP_TEXT_BYTE) begin
						if (in_let.ok && pend_vld_q) state_d = ST_LK_A;
					end else if (cmd.opcode == OP_TEXT_END) begin
						if (pend_vld_q) state_d = ST_LK_A;
						else if (h_en_new) state_d = ST_EM_HELD;
						else state_d = ST_EM_BARE;
					end
				end
			end
			ST_KEYFILL: if (cnt_q == LET_LAST) state_d = ST_IDLE;
			ST_LK_A:    state_d = ST_LK_B;
			ST_LK_B:    state_d = ST_LK_G1;
			ST_LK_G1:   state_d = ST_LK_G2;
			ST_LK_G2:   state_d = ST_LK_G3;
			ST_LK_G3:   state_d = h_en_q ? ST_EM_HELD : ST_EM_P1;
			ST_EM_HELD: if (out_free) state_d = pair_q ? ST_EM_P1 : ST_IDLE;
			ST_EM_P1:   if (out_free) state_d = p2_en ? ST_EM_P2 : ST_IDLE;
			ST_EM_P2:   if (out_free) state_d = ST_IDLE;
			ST_EM_BARE: if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready  = (state_q == ST_IDLE);
		place_req  = 1'b0;
		place_let  = in_let.idx;
		pos_raddr  = (state_q == ST_LK_A) ? a_q : b_q;
		grid_raddr = (state_q == ST_LK_G1) ? a1 : addr2_q;
		load       = 1'b0;
		ld_letter  = '0;
		ld_lv      = 1'b1;
		ld_eot     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				place_req = acc && (cmd.opcode == OP_KEY_BYTE) && in_let.ok;
			end
			ST_KEYFILL: begin
				place_req = (cnt_q != LET_J);
				place_let = cnt_q;
			end
			ST_EM_HELD: begin
				load      = out_free;
				ld_letter = ASCII_A + LETTER_W'(h_let_q);
				ld_eot    = end_q && !pair_q;
			end
			ST_EM_P1: begin
				load      = out_free;
				ld_letter = ASCII_A + LETTER_W'(p1_q);
				ld_eot    = end_q && !p2_en;
			end
			ST_EM_P2: begin
				load      = out_free;
				ld_letter = ASCII_A + LETTER_W'(p2_q);
				ld_eot    = end_q;
			end
			ST_EM_BARE: begin
				load      = out_free;
				ld_lv     = 1'b0;
				ld_eot    = 1'b1;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dir_q       <= 1'b0;
			used_q      <= '0;
			fill_q      <= '0;
			cnt_q       <= '0;
			pend_let_q  <= '0;
			pend_vld_q  <= 1'b0;
			held_let_q  <= '0;
			held_vld_q  <= 1'b0;
			grid_vld_q  <= '0;
			pos_vld_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) dir_q <= cfg_wdata;
			if (place_do) begin
				used_q[place_let]  <= 1'b1;
				pos_vld_q[place_let] <= 1'b1;
				grid_vld_q[fill_q] <= 1'b1;
				fill_q             <= fill_q + 5'd1;
			end
			if (state_q == ST_KEYFILL) cnt_q <= cnt_q + 5'd1;
			else cnt_q <= '0;
			if (acc) begin
				unique case (cmd.opcode)
					OP_KEY_START: begin
						used_q     <= '0;
						fill_q     <= '0;
						pend_vld_q <= 1'b0;
						held_vld_q <= 1'b0;
					end
					OP_TEXT_BYTE: begin
						if (in_let.ok) begin
							if (!pend_vld_q) begin
								pend_let_q <= in_let.idx;
								pend_vld_q <= 1'b1;
							end else begin
								pend_vld_q <= !dir_q && (pend_let_q == in_let.idx);
								held_vld_q <= 1'b0;
							end
						end
					end
					OP_TEXT_END: begin
						pend_vld_q <= 1'b0;
						held_vld_q <= 1'b0;
					end
					default: begin
						pend_vld_q <= pend_vld_q;
					end
				endcase
			end
			if (state_q == ST_LK_G3 && !end_q && dir_q) begin
				held_let_q <= grid_rd;
				held_vld_q <= 1'b1;
			end
			if (load) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		grid_rv_q <= grid_vld_q[grid_raddr];
		grid_ra_q <= grid_raddr;
		pos_rv_q  <= pos_vld_q[pos_raddr];
		pos_ra_q  <= pos_raddr;
		if (acc) begin
			a_q     <= pend_let_q;
			h_let_q <= held_let_q;
			if (cmd.opcode == OP_TEXT_END) begin
				b_q    <= LET_X;
				h_en_q <= h_en_new;
				end_q  <= 1'b1;
				pair_q <= pend_vld_q;
			end else begin
				b_q    <= (!dir_q && pend_let_q == in_let.idx) ? LET_X : in_let.idx;
				h_en_q <= held_vld_q;
				end_q  <= 1'b0;
				pair_q <= 1'b1;
			end
		end
		if (state_q == ST_LK_B) pa_q <= pos_rd;
		if (state_q == ST_LK_G1) addr2_q <= a2;
		if (state_q == ST_LK_G2) p1_q <= grid_rd;
		if (state_q == ST_LK_G3) p2_q <= grid_rd;
		if (load) begin
			res_letter_q <= ld_letter;
			res_lv_q     <= ld_lv;
			res_eot_q    <= ld_eot;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.letter       = res_letter_q;
	assign res.letter_valid = res_lv_q;
	assign res.end_of_text  = res_eot_q;
endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming Playfair engine. A predictor inside
// the scoreboard tracks the key grid, the open pair and the held letter, and
// queues the letters each command transfer must produce; every result
// transfer is compared field by field with the oldest queued letter. A short
// directed sequence is followed by random key/text phases and noise, with
// bursty commands, a stalling result sink and direction changes between
// phases.
// ----------------------------------------------------------------------------
module tb_top;
	import pce_pkg::*;

	localparam int GRID_SIDE  = 5;
	localparam int BACK_STEP  = 4;
	localparam int ITEM_COUNT = 410;
	localparam int DRAIN      = 40;
	localparam int IDLE_LIMIT = 4000;

	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic                letter_valid;
		logic                end_of_text;
	} cipher_out_t;

	class cipher_scoreboard;
		logic [LET_IDX_W-1:0] grid[GRID_CELLS];
		logic [LET_IDX_W-1:0] slot_of[ALPHA_SIZE];
		logic [ALPHA_SIZE-1:0] placed;
		int                    fill;
		logic [LET_IDX_W-1:0] open_let;
		bit                    open_v;
		logic [LET_IDX_W-1:0] held_let;
		bit                    held_v;
		bit                    decrypt;
		int                    emitted;
		cipher_out_t           letters_due[$];
		int                    errors;

		function new();
			for (int s = 0; s < GRID_CELLS; s++) begin
				grid[s] = (s < LET_J) ? LET_IDX_W'(s) : LET_IDX_W'(s + 1);
				slot_of[grid[s]] = LET_IDX_W'(s);
			end
			slot_of[LET_J] = slot_of[LET_I];
			placed  = '0;
			fill    = 0;
			open_v  = 0;
			open_let = '0;
			held_v  = 0;
			held_let = '0;
			decrypt = 0;
			errors  = 0;
		endfunction

		function bit letter_of(input logic [CHAR_W-1:0] b, output logic [LET_IDX_W-1:0] idx);
			int c = b;
			idx = '0;
			if (c >= 97 && c <= 122) c -= 32;
			if (c < 65 || c > 90) return 0;
			idx = LET_IDX_W'(c - 65);
			if (idx == LET_J) idx = LET_I;
			return 1;
		endfunction

		function void place(input logic [LET_IDX_W-1:0] c);
			if (placed[c] || fill >= GRID_CELLS) return;
			grid[fill] = c;
			slot_of[c] = LET_IDX_W'(fill);
			if (c == LET_I) slot_of[LET_J] = LET_IDX_W'(fill);
			fill++;
			placed[c] = 1'b1;
		endfunction

		function void cipher_pair(input logic [LET_IDX_W-1:0] a, input logic [LET_IDX_W-1:0] b,
			output logic [LET_IDX_W-1:0] o1, output logic [LET_IDX_W-1:0] o2);
			int pa, pb, ra, ca, rb, cb, sh;
			pa = slot_of[a];
			pb = slot_of[b];
			ra = pa / GRID_SIDE;
			ca = pa % GRID_SIDE;
			rb = pb / GRID_SIDE;
			cb = pb % GRID_SIDE;
			sh = decrypt ? BACK_STEP : 1;
			if (ra == rb) begin
				o1 = grid[ra * GRID_SIDE + (ca + sh) % GRID_SIDE];
				o2 = grid[rb * GRID_SIDE + (cb + sh) % GRID_SIDE];
			end else if (ca == cb) begin
				o1 = grid[((ra + sh) % GRID_SIDE) * GRID_SIDE + ca];
				o2 = grid[((rb + sh) % GRID_SIDE) * GRID_SIDE + cb];
			end else begin
				o1 = grid[ra * GRID_SIDE + cb];
				o2 = grid[rb * GRID_SIDE + ca];
			end
		endfunction

		function void queue_letter(input logic [LET_IDX_W-1:0] l, input bit v);
			cipher_out_t r;
			r.letter       = v ? LETTER_W'(ASCII_A + l) : '0;
			r.letter_valid = v;
			r.end_of_text  = 1'b0;
			letters_due.insert(letters_due.size(), r);
			emitted++;
		endfunction

		function void note_command(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch);
			logic [LET_IDX_W-1:0] c, p1, p2;
			emitted = 0;
			case (op)
				OP_KEY_START: begin
					placed   = '0;
					fill     = 0;
					open_v   = 0;
					open_let = '0;
					held_v   = 0;
					held_let = '0;
				end
				OP_KEY_BYTE: begin
					if (letter_of(ch, c)) place(c);
				end
				OP_KEY_END: begin
					for (int l = 0; l < ALPHA_SIZE; l++)
						if (l != LET_J) place(LET_IDX_W'(l));
				end
				OP_TEXT_BYTE: begin
					if (!letter_of(ch, c)) return;
					if (!open_v) begin
						open_let = c;
						open_v   = 1;
						return;
					end
					if (held_v) begin
						queue_letter(held_let, 1);
						held_v   = 0;
						held_let = '0;
					end
					if (!decrypt) begin
						if (open_let == c) begin
							cipher_pair(open_let, LET_X, p1, p2);
						end else begin
							cipher_pair(open_let, c, p1, p2);
							open_v = 0;
						end
						queue_letter(p1, 1);
						queue_letter(p2, 1);
					end else begin
						cipher_pair(open_let, c, p1, p2);
						open_v = 0;
						queue_letter(p1, 1);
						held_let = p2;
						held_v   = 1;
					end
				end
				OP_TEXT_END: begin
					if (held_v && (open_v || !decrypt || held_let != LET_X))
						queue_letter(held_let, 1);
					if (open_v) begin
						cipher_pair(open_let, LET_X, p1, p2);
						queue_letter(p1, 1);
						if (!decrypt || p2 != LET_X) queue_letter(p2, 1);
					end
					if (emitted == 0) queue_letter('0, 0);
					letters_due[letters_due.size() - 1].end_of_text = 1'b1;
					open_v   = 0;
					open_let = '0;
					held_v   = 0;
					held_let = '0;
				end
				default: ;
			endcase
		endfunction

		function void check_result(input cipher_out_t got);
			cipher_out_t want;
			if (letters_due.size() == 0) begin
				$error("unexpected result: letter %0d letter_valid %0b end_of_text %0b",
					got.letter, got.letter_valid, got.end_of_text);
				errors++;
				return;
			end
			want = letters_due.pop_front();
			if (got.letter !== want.letter) begin
				$error("letter: expected %0d, actual %0d", want.letter, got.letter);
				errors++;
			end
			if (got.letter_valid !== want.letter_valid) begin
				$error("letter_valid: expected %0b, actual %0b", want.letter_valid,
					got.letter_valid);
				errors++;
			end
			if (got.end_of_text !== want.end_of_text) begin
				$error("end_of_text: expected %0b, actual %0b", want.end_of_text,
					got.end_of_text);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	pce_cmd_if cmd_ch();
	pce_res_if res_ch();

	cipher_scoreboard sb = new();

	int burst_left;
	int items_sent;
	int idle_cycles;

	playfair_cipher_engine_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result sink: stall on one of four patterns, redrawn when its run ends
	initial begin
		int mode;
		int left;
		res_ch.ready = 1'b0;
		left = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 120);
			end
			left--;
			case (mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= 1'($urandom_range(0, 1));
				2: res_ch.ready <= ($urandom_range(0, 5) == 0);
				default: res_ch.ready <= (left % 4 != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result({res_ch.letter, res_ch.letter_valid, res_ch.end_of_text});
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic logic [CHAR_W-1:0] letter_byte();
		int l;
		l = ($urandom_range(0, 9) == 0) ? int'(LET_X) : int'($urandom_range(0, 25));
		return $urandom_range(0, 1) ? CHAR_W'(65 + l) : CHAR_W'(97 + l);
	endfunction

	task automatic push(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 12));
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.opcode    <= op;
		cmd_ch.char_code <= ch;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		sb.note_command(op, ch);
		burst_left--;
		items_sent++;
	endtask

	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		while (sb.letters_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_direction(input logic d);
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.decrypt = d;
	endtask

	task automatic send_key();
		int n;
		if ($urandom_range(0, 4) != 0) push(OP_KEY_START, CHAR_W'($urandom_range(0, 255)));
		n = ($urandom_range(0, 5) == 0) ? int'($urandom_range(20, 34)) : int'($urandom_range(0, 10));
		for (int i = 0; i < n; i++)
			push(OP_KEY_BYTE, ($urandom_range(0, 7) == 0) ? CHAR_W'($urandom_range(0, 255))
				: letter_byte());
		if ($urandom_range(0, 7) != 0) push(OP_KEY_END, CHAR_W'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0) push(OP_KEY_END, CHAR_W'($urandom_range(0, 255)));
	endtask

	task automatic send_text(input int n);
		logic [CHAR_W-1:0] b;
		logic [CHAR_W-1:0] prev;
		int r;
		prev = letter_byte();
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				b = CHAR_W'($urandom_range(0, 255));
			else if (r <= 2)
				b = prev;
			else
				b = letter_byte();
			push(OP_TEXT_BYTE, b);
			prev = b;
		end
	endtask

	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++)
			push(OPCODE_W'($urandom_range(0, 7)), CHAR_W'($urandom_range(0, 255)));
	endtask

	initial begin
		int kind;
		arst_n           = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.opcode    = OP_KEY_START;
		cmd_ch.char_code = '0;
		cfg_we           = 1'b0;
		cfg_wdata        = 1'b0;
		burst_left       = 0;
		items_sent       = 0;
		idle_cycles      = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty text, text on the default grid, key entry corner cases
		set_direction(1'b0);
		push(OP_TEXT_END, 8'h00);
		push(OP_TEXT_BYTE, "h");
		push(OP_TEXT_BYTE, "I");
		push(OP_KEY_START, 8'hFF);
		push(OP_KEY_BYTE, "p");
		push(OP_KEY_BYTE, "J");
		push(OP_KEY_BYTE, "i");
		push(OP_KEY_BYTE, 8'hFF);
		push(OP_KEY_BYTE, 8'h00);
		push(3'd7, 8'hA5);
		push(3'd5, 8'h00);
		push(OP_KEY_BYTE, "Z");
		push(OP_KEY_BYTE, "x");
		push(OP_KEY_END, 8'h00);
		push(OP_KEY_END, 8'h00);
		push(OP_TEXT_BYTE, "A");
		push(OP_TEXT_BYTE, "a");
		push(OP_TEXT_BYTE, "{");
		push(OP_TEXT_BYTE, "z");
		push(OP_TEXT_BYTE, "X");
		push(OP_TEXT_BYTE, "x");
		push(OP_TEXT_END, 8'h00);
		wait_idle();
		set_direction(1'b1);
		push(OP_TEXT_BYTE, "B");
		push(OP_TEXT_BYTE, "@");
		push(OP_TEXT_BYTE, "x");
		push(OP_TEXT_BYTE, "c");
		push(OP_TEXT_BYTE, "X");
		push(OP_TEXT_END, 8'h00);
		wait_idle();

		while (items_sent < ITEM_COUNT) begin
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				if ($urandom_range(0, 3) != 0) send_key();
				send_text($urandom_range(0, 14));
				if ($urandom_range(0, 4) != 0) push(OP_TEXT_END, CHAR_W'($urandom_range(0, 255)));
			end else if (kind <= 7) begin
				send_text($urandom_range(1, 9));
				if ($urandom_range(0, 1) != 0) push(OP_TEXT_END, CHAR_W'($urandom_range(0, 255)));
			end else begin
				send_noise($urandom_range(3, 12));
			end
			wait_idle();
			if ($urandom_range(0, 1) != 0) set_direction(1'($urandom_range(0, 1)));
		end

		wait_idle();
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### sim.f
rtl/pce_pkg.sv
rtl/pce_cmd_if.sv
rtl/pce_res_if.sv
rtl/pce_ram.sv
rtl/playfair_cipher_engine_core.sv
tb/tb_top.sv
